// File: rtl/fsd_pkg.sv
// Shared types and constants of the Floyd-Steinberg RGB dither block.
`default_nettype none
package fsd_pkg;

  // Pixel channel and configuration port geometry.
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // Register index map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_RED_LEVELS   = 3'd2,
    CFG_GREEN_LEVELS = 3'd3,
    CFG_BLUE_LEVELS  = 3'd4
  } cfg_idx_e;

  // Register reset values.
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [8:0]  RST_LEVELS       = 9'd2;

  // Register limits.
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [8:0]  MIN_LEVELS = 9'd2;
  localparam logic [8:0]  MAX_LEVELS = 9'd256;
  localparam logic [7:0]  TWO_LEVEL_STEP = 8'd128;
  localparam logic [7:0]  FULL_SCALE     = 8'd255;

  // Error diffusion weights (sixteenths).
  localparam logic [3:0] WGT_RIGHT       = 4'd7;
  localparam logic [3:0] WGT_BELOW_LEFT  = 4'd3;
  localparam logic [3:0] WGT_BELOW       = 4'd5;
  localparam logic [3:0] WGT_BELOW_RIGHT = 4'd1;

  // Divider lane geometry: nine quotient bits, one per iteration.
  localparam int unsigned DIV_N = 9;

  // Control of the divider lanes.
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: rtl/fsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fsd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, updated only while re_i is high.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsd_div.sv
// Restoring divider lane: nine-bit dividend, eight-bit divisor, one bit per step cycle.
`default_nettype none
module fsd_div (
  input  wire logic                          clk_i,
  input  wire fsd_pkg::div_ctl_t             ctl_i,
  input  wire logic [fsd_pkg::DIV_N-1:0]     dividend_i,
  input  wire logic [7:0]                    divisor_i,
  output logic      [fsd_pkg::DIV_N-1:0]     quotient_o
);

  logic [7:0]                remainder_q, remainder_d;
  logic [fsd_pkg::DIV_N-1:0] shift_q, shift_d;
  logic [8:0]                trial;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial       = {remainder_q, shift_q[fsd_pkg::DIV_N-1]};
    remainder_d = remainder_q;
    shift_d     = shift_q;
    if (ctl_i.start) begin
      remainder_d = '0;
      shift_d     = dividend_i;
    end else if (ctl_i.step) begin
      if (trial >= {1'b0, divisor_i}) begin
        remainder_d = 8'(trial - {1'b0, divisor_i});
        shift_d     = {shift_q[fsd_pkg::DIV_N-2:0], 1'b1};
      end else begin
        remainder_d = trial[7:0];
        shift_d     = {shift_q[fsd_pkg::DIV_N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    remainder_q <= remainder_d;
    shift_q     <= shift_d;
  end

  assign quotient_o = shift_q;

endmodule
`default_nettype wire

// File: rtl/floyd_steinberg_dither_rgb.sv
// Floyd-Steinberg error-diffusion dither for a raster stream of 8-bit RGB pixels.
//
// Input items arrive on s_axis: tuser is 0 for a pixel and 1 for a flush item.
// Result items leave on m_axis, tlast marks the final pixel of a frame.
// Frame size and per-channel level counts are written on the cfg port; the
// user must do so only while the block is idle, which the block does not enforce.
// Pixels wait in a ring memory of two rows until all their neighbours have
// arrived, so results lag the input by frame_width+1 pixel items. A flush
// item releases the oldest waiting pixel.
// An item that gives no result leaves the block idle for the next item. An
// item that gives a result takes one ring read, two nine-step divisions in the
// shared divider lanes (step size, then rounding), and a read and a write
// of the ring for each of up to four neighbours on its single write port.
// The result waits in an output register; the next item is taken meanwhile
// and only its own result waits for the receiver.
// Reset empties the ring (the pending count goes to zero) and restores the
// register defaults; the ring memory itself is not cleared.
`default_nettype none
module floyd_steinberg_dither_rgb #(
  parameter int unsigned MAX_WIDTH = fsd_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input items.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // in_red, in_green, in_blue
  input  wire logic                              s_axis_tuser,  // kind
  // Result items.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [23:0]                       m_axis_tdata,  // out_red, out_green, out_blue
  output logic                                   m_axis_tlast   // frame_done
);

  localparam int unsigned RING  = 2 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(RING);
  localparam int unsigned PW    = $clog2(MAX_WIDTH + 3);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RD     = 10'b0000000010,
    S_LOAD   = 10'b0000000100,
    S_SDIV   = 10'b0000001000,
    S_QSTART = 10'b0000010000,
    S_QDIV   = 10'b0000100000,
    S_ERR    = 10'b0001000000,
    S_NB_RD  = 10'b0010000000,
    S_NB_WR  = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [8:0]  levels_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= fsd_pkg::RST_FRAME_WIDTH;
      height_q    <= fsd_pkg::RST_FRAME_HEIGHT;
      levels_q[0] <= fsd_pkg::RST_LEVELS;
      levels_q[1] <= fsd_pkg::RST_LEVELS;
      levels_q[2] <= fsd_pkg::RST_LEVELS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fsd_pkg::CFG_FRAME_WIDTH:  width_q     <= cfg_data_i[10:0];
        fsd_pkg::CFG_FRAME_HEIGHT: height_q    <= cfg_data_i;
        fsd_pkg::CFG_RED_LEVELS:   levels_q[0] <= cfg_data_i[8:0];
        fsd_pkg::CFG_GREEN_LEVELS: levels_q[1] <= cfg_data_i[8:0];
        fsd_pkg::CFG_BLUE_LEVELS:  levels_q[2] <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and level counts, clamped to their legal ranges.
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [8:0]    lev_eff [3];

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = 13'd1;
    end else if (height_q > fsd_pkg::MAX_HEIGHT) begin
      h_eff = fsd_pkg::MAX_HEIGHT;
    end else begin
      h_eff = height_q;
    end
    for (int c = 0; c < 3; c++) begin
      if (levels_q[c] < fsd_pkg::MIN_LEVELS) begin
        lev_eff[c] = fsd_pkg::MIN_LEVELS;
      end else if (levels_q[c] > fsd_pkg::MAX_LEVELS) begin
        lev_eff[c] = fsd_pkg::MAX_LEVELS;
      end else begin
        lev_eff[c] = levels_q[c];
      end
    end
  end

  // Ring position state.
  logic [AW-1:0] head_q, head_d;
  logic [PW-1:0] pending_q, pending_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [11:0]   out_row_q, out_row_d;

  logic last_col, has_below;
  assign last_col  = (32'(out_col_q) + 32'd1) >= 32'(w_eff);
  assign has_below = ({1'b0, out_row_q} + 13'd1) < h_eff;

  // Ring address: head plus an offset, wrapped once.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [PW-1:0] offs);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW + 1)'(offs);
    if (32'(sum) >= RING) begin
      sum = sum - (AW + 1)'(RING);
    end
    return sum[AW-1:0];
  endfunction

  // Ring memory.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0]   ram_wdata, ram_rdata;

  fsd_ram #(
    .WIDTH (24),
    .DEPTH (RING)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Divider lanes, one per channel (index 0 red, 1 green, 2 blue).
  fsd_pkg::div_ctl_t         div_ctl;
  logic [fsd_pkg::DIV_N-1:0] div_dividend [3];
  logic [7:0]                div_divisor  [3];
  logic [fsd_pkg::DIV_N-1:0] div_quot     [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    fsd_div u_div (
      .clk_i      (clk_i),
      .ctl_i      (div_ctl),
      .dividend_i (div_dividend[g]),
      .divisor_i  (div_divisor[g]),
      .quotient_o (div_quot[g])
    );
  end

  // Datapath registers of the pixel being quantized.
  logic [7:0]    pix_q   [3];
  logic [7:0]    step_q  [3];
  logic [7:0]    qv_q    [3];
  logic signed [8:0] err_q [3];
  logic [3:0]    dcnt_q, dcnt_d;
  logic [1:0]    nb_q, nb_d;
  logic [AW-1:0] nb_addr_q;

  // Output register.
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        out_last_q;
  logic        out_load;

  // Step size from the first division; two levels use a fixed step.
  logic [7:0] step_new [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      step_new[c] = (lev_eff[c] == fsd_pkg::MIN_LEVELS) ? fsd_pkg::TWO_LEVEL_STEP
                                                        : div_quot[c][7:0];
    end
  end

  // Divider operand selection; the divisor is held for the whole division.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ((state_q == S_LOAD) || (state_q == S_SDIV)) begin
        div_dividend[c] = {1'b0, fsd_pkg::FULL_SCALE};
        div_divisor[c]  = 8'(lev_eff[c] - 9'd1);
      end else begin
        div_dividend[c] = {1'b0, pix_q[c]} + {2'b0, step_new[c][7:1]};
        div_divisor[c]  = (state_q == S_QSTART) ? step_new[c] : step_q[c];
      end
    end
  end

  // Neighbour selection: offset, weight and whether the share applies.
  logic [PW-1:0] nb_offs;
  logic [3:0]    nb_wgt;
  logic          nb_en;

  always_comb begin
    unique case (nb_q)
      2'd0: begin
        nb_offs = PW'(1);
        nb_wgt  = fsd_pkg::WGT_RIGHT;
        nb_en   = !last_col;
      end
      2'd1: begin
        nb_offs = PW'(w_eff) - PW'(1);
        nb_wgt  = fsd_pkg::WGT_BELOW_LEFT;
        nb_en   = has_below && (out_col_q != '0);
      end
      2'd2: begin
        nb_offs = PW'(w_eff);
        nb_wgt  = fsd_pkg::WGT_BELOW;
        nb_en   = has_below;
      end
      default: begin
        nb_offs = PW'(w_eff) + PW'(1);
        nb_wgt  = fsd_pkg::WGT_BELOW_RIGHT;
        nb_en   = has_below && !last_col;
      end
    endcase
  end

  // Neighbour update: add the truncated weighted share and clamp to 0..255.
  logic [23:0] nb_new;
  always_comb begin
    logic signed [12:0] prod;
    logic signed [12:0] share;
    logic signed [12:0] sum;
    for (int c = 0; c < 3; c++) begin
      prod  = $signed({1'b0, nb_wgt}) * 13'(err_q[c]);
      share = (prod < 0) ? ((prod + 13'sd15) >>> 4) : (prod >>> 4);
      sum   = $signed({5'b0, ram_rdata[23-8*c -: 8]}) + share;
      if (sum < 0) begin
        nb_new[23-8*c -: 8] = 8'd0;
      end else if (sum > 13'sd255) begin
        nb_new[23-8*c -: 8] = 8'd255;
      end else begin
        nb_new[23-8*c -: 8] = sum[7:0];
      end
    end
  end

  // Sequencer.
  logic s_fire;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    pending_d = pending_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    dcnt_d    = dcnt_q;
    nb_d      = nb_q;
    ram_we    = 1'b0;
    ram_waddr = ring_addr(head_q, pending_q);
    ram_wdata = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    ram_re    = 1'b0;
    ram_raddr = head_q;
    div_ctl   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (!s_axis_tuser) begin
            ram_we    = 1'b1;
            pending_d = pending_q + PW'(1);
            if ((32'(pending_q) + 32'd1) >= (32'(w_eff) + 32'd2)) begin
              state_d = S_RD;
            end
          end else if (pending_q != '0) begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        div_ctl.start = 1'b1;
        dcnt_d        = '0;
        state_d       = S_SDIV;
      end
      S_SDIV: begin
        div_ctl.step = 1'b1;
        dcnt_d       = dcnt_q + 4'd1;
        if (dcnt_q == 4'(fsd_pkg::DIV_N - 1)) begin
          state_d = S_QSTART;
        end
      end
      S_QSTART: begin
        div_ctl.start = 1'b1;
        dcnt_d        = '0;
        state_d       = S_QDIV;
      end
      S_QDIV: begin
        div_ctl.step = 1'b1;
        dcnt_d       = dcnt_q + 4'd1;
        if (dcnt_q == 4'(fsd_pkg::DIV_N - 1)) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        nb_d    = 2'd0;
        state_d = S_NB_RD;
      end
      S_NB_RD: begin
        if (nb_en && (nb_offs < pending_q)) begin
          ram_re    = 1'b1;
          ram_raddr = ring_addr(head_q, nb_offs);
          state_d   = S_NB_WR;
        end else if (nb_q == 2'd3) begin
          state_d = S_FIN;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end
      S_NB_WR: begin
        ram_we    = 1'b1;
        ram_waddr = nb_addr_q;
        ram_wdata = nb_new;
        if (nb_q == 2'd3) begin
          state_d = S_FIN;
        end else begin
          nb_d    = nb_q + 2'd1;
          state_d = S_NB_RD;
        end
      end
      S_FIN: begin
        if (out_load) begin
          head_d    = ring_addr(head_q, PW'(1));
          pending_d = pending_q - PW'(1);
          if (last_col) begin
            out_col_d = '0;
            out_row_d = has_below ? out_row_q + 12'd1 : 12'd0;
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      pending_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      dcnt_q      <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      pending_q <= pending_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      dcnt_q    <= dcnt_d;
      nb_q      <= nb_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: pixel, step, quantized value, error, neighbour address and output.
  always_ff @(posedge clk_i) begin
    logic [16:0] prod;
    for (int c = 0; c < 3; c++) begin
      if (state_q == S_LOAD) begin
        pix_q[c] <= ram_rdata[23-8*c -: 8];
      end
      if (state_q == S_QSTART) begin
        step_q[c] <= step_new[c];
      end
      if (state_q == S_ERR) begin
        prod     = div_quot[c] * step_q[c];
        qv_q[c]  <= (prod > 17'd255) ? 8'd255 : prod[7:0];
        err_q[c] <= $signed({1'b0, pix_q[c]}) -
                    $signed({1'b0, ((prod > 17'd255) ? 8'd255 : prod[7:0])});
      end
    end
    if (state_q == S_NB_RD) begin
      nb_addr_q <= ram_raddr;
    end
    if (out_load) begin
      out_data_q <= {qv_q[2], qv_q[1], qv_q[0]};
      out_last_q <= last_col && !has_below;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
